/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the dispatcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SJF_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sjf dispatcher assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SJF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sjf dispatcher assertion failed");

`endif

/* hw/rtl/sjf_pkg.sv */
// Types and constants shared by the shortest-job-first dispatcher.
`default_nettype none
package sjf_pkg;

  // One queued job.
  typedef struct packed {
    logic [15:0] burst;
    logic [15:0] arr;
    logic [7:0]  id;
  } sjf_entry_t;

  // Command broadcast to every cell of the queue chain.
  typedef struct packed {
    logic       pop;   // shift all entries one cell toward the head
    logic       push;  // sorted insert of job
    sjf_entry_t job;
  } sjf_cmd_t;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [31:0] CLK_MAX = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

/* hw/rtl/sjf_cell.sv */
// One cell of the sorted ready queue: holds a job and trades with its neighbors.
`default_nettype none
module sjf_cell
  import sjf_pkg::*;
(
  input  wire logic       clk,
  input  wire sjf_cmd_t   cmd,
  input  wire logic       occupied,  // cell holds a queued job
  input  wire logic       at_tail,   // first free cell
  input  wire sjf_entry_t left_entry,
  input  wire logic       left_gt,
  input  wire sjf_entry_t right_entry,
  output sjf_entry_t      entry,
  output logic            gt         // holds a job with longer burst than cmd.job
);

  sjf_entry_t entry_r;
  sjf_entry_t entry_nxt;

  assign entry = entry_r;
  assign gt    = occupied && (entry_r.burst > cmd.job.burst);

  // Pop shifts toward the head; push opens a slot after all shorter-or-equal bursts
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.pop) begin
      entry_nxt = right_entry;
    end else if (cmd.push) begin
      if (left_gt) begin
        entry_nxt = left_entry;
      end else if (gt || at_tail) begin
        entry_nxt = cmd.job;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

/* hw/rtl/sjf_chain.sv */
// Row of queue cells kept sorted by burst, shortest job at the head.
`default_nettype none
module sjf_chain
  import sjf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire sjf_cmd_t         cmd,
  input  wire logic [CNT_W-1:0] count,
  output sjf_entry_t            head
);

  sjf_entry_t entries [QUEUE_DEPTH];
  logic       gts     [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    sjf_entry_t left_e;
    logic       left_g;
    sjf_entry_t right_e;

    // Tie the chain ends: no longer-burst job to the left of the head
    if (i == 0) begin : g_first
      assign left_e = cmd.job;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_e = entries[i-1];
      assign left_g = gts[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = entries[i];
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    sjf_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (count > CNT_W'(i)),
      .at_tail     (count == CNT_W'(i)),
      .left_entry  (left_e),
      .left_gt     (left_g),
      .right_entry (right_e),
      .entry       (entries[i]),
      .gt          (gts[i])
    );
  end

  assign head = entries[0];

endmodule
`default_nettype wire

/* hw/rtl/sjf_nonpreemptive_dispatcher.sv */
// Top level of the non-preemptive shortest-job-first dispatcher.
//
//  Channel  Direction  Payload
//  in_*     slave      tdata {burst, arrival, job id}, tlast = batch end
//  out_*    master     tdata {wait, turnaround, completion, end, start, id},
//                      tuser = status, tlast = last result of the job
//
// A job is accepted in S_IDLE and then queued or dropped in S_PRE, after any
// dispatches that its arrival causes. Each dispatch from the head cell yields one
// result; the cell chain shifts once per dispatch or insert.
// A job is accepted only when the previous one has finished its dispatches.
// Output stalls hold the sequencer; rst_n clears count, clock and handshakes.
`default_nettype none
module sjf_nonpreemptive_dispatcher
  import sjf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [39:0]  in_tdata,   // job_id[7:0], arrival_time[23:8], burst_length[39:24]
  input  wire logic         in_tlast,   // batch_end
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [167:0]      out_tdata,  // run_id[7:0], start_time[39:8], end_time[71:40],
                                        // completion_time[103:72], turnaround[135:104],
                                        // waiting[167:136]
  output logic [1:0]        out_tuser,  // status[1:0]
  output logic              out_tlast   // run_last
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PRE   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      clock_r, clock_nxt;
  sjf_entry_t       job_r, job_nxt;
  logic             batch_r, batch_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [167:0]     out_data_r, out_data_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  sjf_cmd_t   cmd;
  sjf_entry_t head;

  sjf_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CNT_W       (CNT_W)
  ) u_chain (
    .clk   (clk),
    .cmd   (cmd),
    .count (cnt_r),
    .head  (head)
  );

  // Schedule of the head job against the current clock
  logic [32:0] sum;
  logic        sat;
  logic [31:0] comp, end_t, tat, wt, wt_run, tat_sat;
  logic        out_free, clk_below, go_disp;

  assign sum     = {1'b0, clock_r} + 33'(head.burst);
  assign sat     = sum[32];
  assign comp    = sat ? CLK_MAX : sum[31:0];
  assign end_t   = comp - 32'd1;
  assign wt_run  = clock_r - 32'(head.arr);
  assign tat_sat = CLK_MAX - 32'(head.arr);
  assign tat     = sat ? tat_sat : wt_run + 32'(head.burst);
  assign wt      = sat ? tat_sat - 32'(head.burst) : wt_run;

  assign out_free  = !out_valid_r || out_tready;
  assign clk_below = clock_r < 32'(job_r.arr);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // Sequence: dispatch below arrival, queue or drop, then drain on batch end
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    clock_nxt      = clock_r;
    job_nxt        = job_r;
    batch_nxt      = batch_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    cmd.pop        = 1'b0;
    cmd.push       = 1'b0;
    cmd.job        = job_r;
    go_disp        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          job_nxt.id    = in_tdata[7:0];
          job_nxt.arr   = in_tdata[23:8];
          job_nxt.burst = in_tdata[39:24];
          batch_nxt     = in_tlast;
          state_nxt     = S_PRE;
        end
      end
      S_PRE: begin
        if (cnt_r != '0 && clk_below) begin
          go_disp = out_free;
          if (out_free) begin
            out_last_nxt = !batch_r && !((cnt_r > CNT_ONE) && (comp < 32'(job_r.arr)));
          end
        end else if (cnt_r == CNT_FULL) begin
          // Drop the job: zero times, status flags it
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_data_nxt   = {160'd0, job_r.id};
            out_status_nxt = ST_DROP;
            out_last_nxt   = !batch_r;
            state_nxt      = batch_r ? S_DRAIN : S_IDLE;
          end
        end else begin
          if (cnt_r == '0 && clk_below) begin
            clock_nxt = 32'(job_r.arr);
          end
          cmd.push  = 1'b1;
          cnt_nxt   = cnt_r + CNT_ONE;
          state_nxt = batch_r ? S_DRAIN : S_IDLE;
        end
      end
      S_DRAIN: begin
        go_disp = out_free;
        if (out_free) begin
          out_last_nxt = (cnt_r == CNT_ONE);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Dispatch the head job and advance the clock
    if (go_disp) begin
      cmd.pop        = 1'b1;
      cnt_nxt        = cnt_r - CNT_ONE;
      clock_nxt      = comp;
      out_valid_nxt  = 1'b1;
      out_data_nxt   = {wt, tat, comp, end_t, clock_r, head.id};
      out_status_nxt = sat ? ST_SAT : ST_OK;
      if (state_r == S_DRAIN && cnt_r == CNT_ONE) begin
        clock_nxt = '0;
        state_nxt = S_IDLE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    job_r        <= job_nxt;
    batch_r      <= batch_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  `SJF_ASSERT(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_FULL)
  `SJF_ASSERT(a_drain_nonempty, clk, rst_n, state_r == S_DRAIN, cnt_r != '0)
  `SJF_ASSERT(a_drop_full, clk, rst_n, out_valid_r && out_status_r == ST_DROP, cnt_r == CNT_FULL)
  `SJF_ASSERT_NXT(a_drain_done, clk, rst_n, state_r == S_DRAIN && go_disp && cnt_r == CNT_ONE,
    state_r == S_IDLE && clock_r == '0 && out_last_r)

endmodule
`default_nettype wire

/* tb/sv/sjf_nonpreemptive_dispatcher_test.sv */
// Self-checking testbench for the non-preemptive shortest-job-first dispatcher.
module sjf_nonpreemptive_dispatcher_test;
  import sjf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  // One schedule line as the block reports it.
  typedef struct packed {
    logic [7:0]  run_id;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [31:0] completion;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic [1:0]  status;
    logic        run_last;
  } sched_run_t;

  // One row of the directed job list; want is used only when typed is set.
  typedef struct {
    logic [7:0]  id;
    logic [15:0] arr;
    logic [15:0] burst;
    logic        batch_end;
    logic        typed;
    sched_run_t  want;
  } job_row_t;

  localparam sched_run_t NO_RUN = '0;
  localparam int N_DIRECTED = 23;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;   // job_id[7:0], arrival_time[23:8], burst_length[39:24]
  logic         in_tlast = 1'b0; // batch_end
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [167:0] out_tdata;       // run_id, start, end, completion, turnaround, waiting
  logic [1:0]   out_tuser;       // status[1:0]
  logic         out_tlast;       // run_last

  // Ready queue of the dispatcher as tracked on the bench side.
  sjf_entry_t  ready_jobs [QUEUE_DEPTH];
  int unsigned ready_count = 0;
  logic [31:0] sched_clock = '0;

  sched_run_t  job_runs[$];      // runs caused by the job just planned
  sched_run_t  pending_runs[$];  // runs still owed by the block, oldest first

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int jobs_sent = 0;
  int runs_checked = 0;
  int drops_seen = 0;
  int max_runs_per_job = 0;
  int mismatches = 0;

  // Directed jobs: extremes, zero burst, late arrival, burst ties, full queue.
  job_row_t dir_rows [N_DIRECTED] = '{
    // Lone job at the top arrival and burst: idle jump, then drain.
    '{8'hAB, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
      '{8'hAB, 32'd65535, 32'd131069, 32'd131070, 32'd65535, 32'd0, ST_OK, 1'b1}},
    // Zero burst at tick zero: end time wraps below the start.
    '{8'h00, 16'h0000, 16'h0000, 1'b1, 1'b1,
      '{8'h00, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, ST_OK, 1'b1}},
    '{8'h01, 16'd100, 16'd50, 1'b0, 1'b0, NO_RUN},
    // Arrival below the clock: queued without dispatch.
    '{8'h02, 16'd10, 16'd3, 1'b0, 1'b0, NO_RUN},
    '{8'h03, 16'd100, 16'd3, 1'b0, 1'b0, NO_RUN},
    '{8'h04, 16'd100, 16'hFFFF, 1'b0, 1'b0, NO_RUN},
    '{8'h05, 16'd100, 16'd1, 1'b0, 1'b0, NO_RUN},
    '{8'h06, 16'd100, 16'd0, 1'b0, 1'b0, NO_RUN},
    '{8'h07, 16'd100, 16'd50, 1'b0, 1'b0, NO_RUN},
    '{8'h08, 16'd100, 16'd7, 1'b0, 1'b0, NO_RUN},
    '{8'h09, 16'd100, 16'd7, 1'b0, 1'b0, NO_RUN},
    '{8'h0A, 16'd100, 16'd2, 1'b0, 1'b0, NO_RUN},
    '{8'h0B, 16'd100, 16'h8000, 1'b0, 1'b0, NO_RUN},
    '{8'h0C, 16'd100, 16'h7FFF, 1'b0, 1'b0, NO_RUN},
    '{8'h0D, 16'd100, 16'd20, 1'b0, 1'b0, NO_RUN},
    '{8'h0E, 16'd100, 16'd1, 1'b0, 1'b0, NO_RUN},
    '{8'h0F, 16'd100, 16'd9, 1'b0, 1'b0, NO_RUN},
    '{8'h10, 16'd100, 16'd4, 1'b0, 1'b0, NO_RUN},
    // Queue full: dropped with zero times.
    '{8'h55, 16'd100, 16'd7, 1'b0, 1'b1,
      '{8'h55, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, ST_DROP, 1'b1}},
    // Dropped job that ends the batch: drop, then drain all sixteen.
    '{8'h56, 16'd100, 16'd1, 1'b1, 1'b0, NO_RUN},
    '{8'hFF, 16'h0000, 16'd1, 1'b0, 1'b0, NO_RUN},
    '{8'hFE, 16'h8000, 16'h8000, 1'b0, 1'b0, NO_RUN},
    '{8'h80, 16'hFFFF, 16'd1, 1'b1, 1'b0, NO_RUN}
  };

  sjf_nonpreemptive_dispatcher #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run the queued job with the shortest burst and advance the clock.
  function automatic void dispatch_shortest();
    sjf_entry_t head;
    sched_run_t r;
    logic [32:0] sum;
    head = ready_jobs[0];
    for (int i = 1; i < ready_count; i++) ready_jobs[i - 1] = ready_jobs[i];
    ready_count--;
    sum = {1'b0, sched_clock} + 33'(head.burst);
    r.run_id = head.id;
    r.start_time = sched_clock;
    if (sum > {1'b0, CLK_MAX}) begin
      r.completion = CLK_MAX;
      r.status = ST_SAT;
    end else begin
      r.completion = sum[31:0];
      r.status = ST_OK;
    end
    sched_clock = r.completion;
    r.end_time = r.completion - 32'd1;
    r.turnaround = (r.completion >= 32'(head.arr)) ? r.completion - 32'(head.arr) : '0;
    r.waiting = (r.turnaround >= 32'(head.burst)) ? r.turnaround - 32'(head.burst) : '0;
    r.run_last = 1'b0;
    job_runs = {job_runs, r};
  endfunction

  // Insert behind every job with an equal or shorter burst.
  function automatic void insert_by_burst(input sjf_entry_t j);
    int unsigned i;
    i = ready_count;
    while (i > 0 && j.burst < ready_jobs[i - 1].burst) begin
      ready_jobs[i] = ready_jobs[i - 1];
      i--;
    end
    ready_jobs[i] = j;
    ready_count++;
  endfunction

  // Work out every run that one arriving job causes.
  function automatic void plan_arrival(input sjf_entry_t j, input logic batch_end);
    sched_run_t r;
    job_runs.delete();
    while (ready_count > 0 && sched_clock < 32'(j.arr)) dispatch_shortest();
    if (ready_count == 0 && sched_clock < 32'(j.arr)) sched_clock = 32'(j.arr);
    if (ready_count >= QUEUE_DEPTH) begin
      r = '0;
      r.run_id = j.id;
      r.status = ST_DROP;
      job_runs = {job_runs, r};
    end else begin
      insert_by_burst(j);
    end
    if (batch_end) begin
      while (ready_count > 0) dispatch_shortest();
      sched_clock = '0;
    end
    if (job_runs.size() > 0) job_runs[job_runs.size() - 1].run_last = 1'b1;
    if (job_runs.size() > max_runs_per_job) max_runs_per_job = job_runs.size();
  endfunction

  function automatic string run_text(input sched_run_t r);
    return $sformatf("id=%0d start=%0d end=%0d comp=%0d tat=%0d wait=%0d status=%0d last=%0d",
                     r.run_id, r.start_time, r.end_time, r.completion, r.turnaround,
                     r.waiting, r.status, r.run_last);
  endfunction

  // Offer one job, hold it until accepted, then book its runs.
  task automatic send_job(input sjf_entry_t j, input logic batch_end,
                          input logic typed, input sched_run_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= j;
    in_tlast  <= batch_end;
    do @(posedge clk); while (!in_tready);
    plan_arrival(j, batch_end);
    if (typed) pending_runs = {pending_runs, want};
    else foreach (job_runs[k]) pending_runs = {pending_runs, job_runs[k]};
    jobs_sent++;
  endtask

  // Drop valid and wait until the block owes nothing.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_runs.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed batches with random content; the rest is noise.
  task automatic run_random_batches(input int n_jobs);
    int sent;
    int mode;
    int len;
    logic [16:0] arr_next;
    sjf_entry_t j;
    logic be;
    sent = 0;
    while (sent < n_jobs) begin
      mode = $urandom_range(99);
      len = (mode < 10) ? $urandom_range(17, 20) : $urandom_range(1, 12);
      arr_next = ($urandom_range(3) == 0) ? 17'($urandom_range(0, 65535))
                                          : 17'($urandom_range(0, 64));
      for (int k = 0; k < len; k++) begin
        j.id = 8'($urandom_range(0, 255));
        if (mode >= 85) begin
          // Noise: arrival anywhere, burst anywhere including zero.
          j.arr = 16'($urandom_range(0, 65535));
          j.burst = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
          be = (k == len - 1) || ($urandom_range(7) == 0);
        end else begin
          // Full-queue batches keep one arrival; others step forward.
          if (mode >= 10) arr_next = arr_next + 17'($urandom_range(0, 30));
          if (arr_next > 17'h0FFFF) arr_next = 17'h0FFFF;
          j.arr = arr_next[15:0];
          case ($urandom_range(15))
            0:       j.burst = 16'($urandom_range(1, 65535));
            1:       j.burst = 16'hFFFF;
            default: j.burst = 16'($urandom_range(1, 24));
          endcase
          be = (k == len - 1);
        end
        send_job(j, be, 1'b0, NO_RUN);
        sent++;
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each accepted result with the oldest expected run.
  always @(posedge clk) begin
    sched_run_t got;
    sched_run_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[7:0], out_tdata[39:8], out_tdata[71:40], out_tdata[103:72],
              out_tdata[135:104], out_tdata[167:136], out_tuser, out_tlast};
      if (got.status == ST_DROP) drops_seen++;
      if (pending_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result: %s", $realtime, run_text(got));
      end else begin
        want = pending_runs.pop_front();
        runs_checked++;
        if (got.run_id !== want.run_id || got.start_time !== want.start_time ||
            got.end_time !== want.end_time || got.completion !== want.completion ||
            got.turnaround !== want.turnaround || got.waiting !== want.waiting ||
            got.status !== want.status || got.run_last !== want.run_last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch, expected: %s", $realtime, run_text(want));
            $display("[%0t] mismatch, actual:   %s", $realtime, run_text(got));
          end
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    sjf_entry_t j;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed jobs, no idling.
    foreach (dir_rows[i]) begin
      j.id = dir_rows[i].id;
      j.arr = dir_rows[i].arr;
      j.burst = dir_rows[i].burst;
      send_job(j, dir_rows[i].batch_end, dir_rows[i].typed, dir_rows[i].want);
    end
    wait_for_drain();

    // Random, no idling on either side.
    run_random_batches(80);
    wait_for_drain();

    // Hold the receiver off while the sender keeps offering a busy batch.
    hold_req <= hold_req + 1;
    for (int k = 0; k < 12; k++) begin
      j.id = 8'($urandom_range(0, 255));
      j.arr = 16'(k * 5);
      j.burst = 16'($urandom_range(1, 8));
      send_job(j, k == 11, 1'b0, NO_RUN);
    end
    wait_for_drain();

    // Sender idling.
    send_idle_pct = 78;
    run_random_batches(80);
    wait_for_drain();

    // Receiver stalling.
    send_idle_pct = 0;
    stall_pct <= 78;
    run_random_batches(80);
    wait_for_drain();

    // Both sides idling.
    send_idle_pct = 33;
    stall_pct <= 33;
    run_random_batches(80);
    wait_for_drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d jobs (%0d directed), checked %0d results, %0d of them drops.",
             jobs_sent, N_DIRECTED, runs_checked, drops_seen);
    $display("Longest result train per job: %0d; mismatches: %0d.",
             max_runs_per_job, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Watchdog expired with %0d results outstanding.", pending_runs.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

/* sjf_nonpreemptive_dispatcher.f */
+incdir+hw/rtl
hw/rtl/sjf_pkg.sv
hw/rtl/sjf_cell.sv
hw/rtl/sjf_chain.sv
hw/rtl/sjf_nonpreemptive_dispatcher.sv
tb/sv/sjf_nonpreemptive_dispatcher_test.sv
